@@ sv/frame_share_count_table_defines.svh @@
// ---------------------------------------------------------------------------
// Frame share count table assertion macros
// Concurrent assertion wrappers on clk; compiled out under ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef FRAME_SHARE_COUNT_TABLE_DEFINES_SVH
`define FRAME_SHARE_COUNT_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FSCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSCT_ASSERT(label, prop, msg)
`define FSCT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ sv/fsct_pkg.sv @@
// ---------------------------------------------------------------------------
// Frame share count table package
// Table geometry, slot and result layouts, mode and sequencer codes.
// ---------------------------------------------------------------------------
package fsct_pkg;

  localparam int TABLE_SIZE = 8192;
  localparam int SLOT_BITS  = $clog2(TABLE_SIZE);
  localparam int FRAME_BITS = 40;
  localparam int COUNT_BITS = 16;
  localparam int REF_BITS   = 16;
  localparam int MODE_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD   = 2'd0,
    MODE_DROP  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  used;
    logic [FRAME_BITS-1:0] frame;
    logic [COUNT_BITS-1:0] count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic                  dropped;
    logic                  release_frame;
    logic                  found;
    logic [REF_BITS-1:0]   ref_count;
  } res_t;

endpackage

@@ sv/fsct_ram.sv @@
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/frame_share_count_table.sv @@
// ---------------------------------------------------------------------------
// Frame share count table
// Open-addressed reference-count table for shared page frames.
// ---------------------------------------------------------------------------
// Each request (add, drop or query) probes the table linearly from the home
// slot, frame_number modulo the table size, until it meets a matching entry,
// an empty slot or has visited every slot. Each probe is a read of the slot
// RAM (ST_RD) followed by a compare/update step (ST_CHK) that may write the
// slot back; a request visits from 1 up to 8192 slots, and a lightly loaded
// table needs a few probes. Only one request is in flight; the next is taken
// once the result has moved to the output register. After reset the slot RAM
// is swept clear, one slot per cycle, across all 8192 slots before the first
// request is taken.
// ---------------------------------------------------------------------------
`include "frame_share_count_table_defines.svh"

module frame_share_count_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fsct_pkg::FRAME_BITS-1:0] in_tdata,  // [39:0] frame_number
  input  logic [fsct_pkg::MODE_BITS-1:0] in_tuser,   // [1:0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fsct_pkg::REF_BITS-1:0]  out_tdata,  // [15:0] ref_count
  output logic [2:0]                     out_tuser   // [0] found, [1] release_frame,
                                                     // [2] dropped
);

  import fsct_pkg::*;

  state_t                state_r, state_nxt;
  logic [SLOT_BITS-1:0]  clr_idx_r, clr_idx_nxt;
  logic [SLOT_BITS-1:0]  probe_r, probe_nxt;
  logic [SLOT_BITS-1:0]  step_r, step_nxt;
  logic [MODE_BITS-1:0]  mode_r, mode_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  res_t                  res_r, res_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr;
  slot_t                 ram_wdata;
  slot_t                 rd_slot;

  logic                  hit;
  logic                  empty;
  logic                  last;
  logic                  done;
  logic                  out_free;
  logic [COUNT_BITS-1:0] cnt_adj;

  fsct_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_r),
    .rdata (rd_slot)
  );

  assign hit      = rd_slot.used && (rd_slot.frame == frame_r);
  assign empty    = !rd_slot.used;
  assign last     = &step_r;
  assign done     = hit || empty || last;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_adj  = rd_slot.count + ((mode_r == MODE_ADD) ? COUNT_ONE : COUNT_MAX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (&clr_idx_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_CHK;
      ST_CHK:   state_nxt = done ? ST_OUT : ST_RD;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    clr_idx_nxt   = clr_idx_r;
    probe_nxt     = probe_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    frame_nxt     = frame_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = probe_r;
    ram_wdata     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_IDLE: begin
        mode_nxt  = in_tuser;
        frame_nxt = in_tdata;
        probe_nxt = in_tdata[SLOT_BITS-1:0];
        step_nxt  = '0;
        res_nxt   = '0;
      end
      ST_RD: begin
      end
      ST_CHK: begin
        probe_nxt = probe_r + 1'b1;
        step_nxt  = step_r + 1'b1;
        case (mode_r)
          MODE_ADD: begin
            if (hit) begin
              ram_we              = 1'b1;
              ram_wdata.used      = 1'b1;
              ram_wdata.frame     = frame_r;
              ram_wdata.count     = (rd_slot.count == COUNT_MAX) ? COUNT_MAX : cnt_adj;
              res_nxt.found       = 1'b1;
              res_nxt.ref_count   = REF_BITS'(ram_wdata.count);
            end else if (empty) begin
              ram_we              = 1'b1;
              ram_wdata.used      = 1'b1;
              ram_wdata.frame     = frame_r;
              ram_wdata.count     = COUNT_ONE;
              res_nxt.ref_count   = REF_BITS'(COUNT_ONE);
            end else if (last) begin
              res_nxt.dropped     = 1'b1;
            end
          end
          MODE_DROP: begin
            if (hit) begin
              ram_we        = 1'b1;
              res_nxt.found = 1'b1;
              if (rd_slot.count > COUNT_ONE) begin
                ram_wdata.used    = 1'b1;
                ram_wdata.frame   = frame_r;
                ram_wdata.count   = cnt_adj;
                res_nxt.ref_count = REF_BITS'(cnt_adj);
              end else begin
                res_nxt.release_frame = 1'b1;
              end
            end
          end
          default: begin
            if (hit) begin
              res_nxt.found     = 1'b1;
              res_nxt.ref_count = REF_BITS'(rd_slot.count);
            end
          end
        endcase
      end
      ST_OUT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    step_r  <= step_nxt;
    mode_r  <= mode_nxt;
    frame_r <= frame_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.ref_count;
  assign out_tuser  = {out_r.dropped, out_r.release_frame, out_r.found};

  `FSCT_ASSERT(a_accept_reads, in_tvalid && in_tready |=> state_r == ST_RD, "accept did not start a probe")
  `FSCT_ASSERT_ALWAYS(a_clear_blocks, state_r == ST_CLEAR |-> !in_tready, "ready during clear sweep")
  `FSCT_ASSERT(a_write_phase, ram_we |-> (state_r == ST_CLEAR || state_r == ST_CHK), "slot write outside clear or check")
  `FSCT_ASSERT(a_dropped_clean, out_tvalid && out_tuser[2] |-> out_tdata == '0 && !out_tuser[0] && !out_tuser[1], "dropped result carries other fields")
  `FSCT_ASSERT(a_release_clean, out_tvalid && out_tuser[1] |-> out_tdata == '0 && out_tuser[0], "release result without found or with count")

endmodule

@@ dv/tb_frame_share_count_table.sv @@
// ---------------------------------------------------------------------------
// Frame share count table testbench
// Streams add, drop and query requests into the table and checks every
// reply against a scoreboard model with its own copy of the slot array.
// Covers frame extremes, probe wraparound and chains broken by a free,
// under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb_frame_share_count_table;
  timeunit 1ns;
  timeprecision 1ps;

  import fsct_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int N_RANDOM     = 1025;
  localparam int N_QUIET      = 200;
  localparam int POOL_N       = 16;
  localparam int LONG_HOLD    = 300;
  localparam int N_ROWS       = 25;

  localparam logic [MODE_BITS-1:0] MODE_QUERY_ALT = 2'd3;

  localparam logic [FRAME_BITS-1:0] F_ZERO    = '0;
  localparam logic [FRAME_BITS-1:0] F_TOP     = 40'hFF_FFFF_FFFF;
  localparam logic [FRAME_BITS-1:0] F_WRAP    = 40'hFF_FFFF_DFFF;
  localparam logic [FRAME_BITS-1:0] F_ALT_A   = 40'hAA_AAAA_AAAA;
  localparam logic [FRAME_BITS-1:0] F_ALT_5   = 40'h55_5555_5555;
  localparam logic [FRAME_BITS-1:0] F_CHAIN_A = 40'h12_3456_0005;
  localparam logic [FRAME_BITS-1:0] F_CHAIN_B = 40'h00_0000_2005;
  localparam logic [FRAME_BITS-1:0] F_CHAIN_C = 40'h0A_BCDE_4005;

  localparam res_t RES_ABSENT = '0;
  localparam res_t RES_NEW    = '{dropped: 1'b0, release_frame: 1'b0, found: 1'b0,
                                  ref_count: REF_BITS'(1)};
  localparam res_t RES_FREED  = '{dropped: 1'b0, release_frame: 1'b1, found: 1'b1,
                                  ref_count: '0};

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [FRAME_BITS-1:0] frame;
    logic                  typed;
    res_t                  want;
  } req_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [FRAME_BITS-1:0] in_tdata;   // [39:0] frame_number
  logic [MODE_BITS-1:0]  in_tuser;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [REF_BITS-1:0]   out_tdata;  // [15:0] ref_count
  logic [2:0]            out_tuser;  // [0] found, [1] release_frame, [2] dropped

  bit                    share_used  [TABLE_SIZE];
  logic [FRAME_BITS-1:0] share_frame [TABLE_SIZE];
  logic [COUNT_BITS-1:0] share_count [TABLE_SIZE];

  res_t refcount_replies [$];
  int   bad_fields;
  int   cycle_cnt;
  bit   idle_en;
  bit   long_hold;

  req_row_t dir_rows [N_ROWS] = '{
    '{MODE_QUERY,     F_ZERO,    1'b1, RES_ABSENT},
    '{MODE_DROP,      F_ZERO,    1'b1, RES_ABSENT},
    '{MODE_ADD,       F_ZERO,    1'b1, RES_NEW},
    '{MODE_ADD,       F_ZERO,    1'b0, RES_ABSENT},
    '{MODE_QUERY,     F_ZERO,    1'b0, RES_ABSENT},
    '{MODE_ADD,       F_TOP,     1'b1, RES_NEW},
    '{MODE_ADD,       F_WRAP,    1'b1, RES_NEW},
    '{MODE_QUERY,     F_WRAP,    1'b0, RES_ABSENT},
    '{MODE_QUERY_ALT, F_WRAP,    1'b0, RES_ABSENT},
    '{MODE_DROP,      F_ZERO,    1'b0, RES_ABSENT},
    '{MODE_DROP,      F_ZERO,    1'b1, RES_FREED},
    '{MODE_QUERY,     F_WRAP,    1'b0, RES_ABSENT},
    '{MODE_ADD,       F_WRAP,    1'b0, RES_ABSENT},
    '{MODE_DROP,      F_WRAP,    1'b0, RES_ABSENT},
    '{MODE_QUERY_ALT, F_ALT_A,   1'b0, RES_ABSENT},
    '{MODE_ADD,       F_ALT_A,   1'b0, RES_ABSENT},
    '{MODE_ADD,       F_ALT_5,   1'b0, RES_ABSENT},
    '{MODE_DROP,      F_ALT_A,   1'b0, RES_ABSENT},
    '{MODE_DROP,      F_TOP,     1'b0, RES_ABSENT},
    '{MODE_ADD,       F_CHAIN_A, 1'b0, RES_ABSENT},
    '{MODE_ADD,       F_CHAIN_B, 1'b0, RES_ABSENT},
    '{MODE_ADD,       F_CHAIN_C, 1'b0, RES_ABSENT},
    '{MODE_DROP,      F_CHAIN_B, 1'b0, RES_ABSENT},
    '{MODE_QUERY,     F_CHAIN_C, 1'b0, RES_ABSENT},
    '{MODE_DROP,      F_CHAIN_C, 1'b0, RES_ABSENT}
  };

  frame_share_count_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic res_t refcount_update(input logic [MODE_BITS-1:0]  mode,
                                           input logic [FRAME_BITS-1:0] frame);
    res_t        r;
    int unsigned home;
    int unsigned s;
    int          hit;
    r    = '0;
    hit  = -1;
    home = 32'(frame % TABLE_SIZE);
    if (mode == MODE_ADD) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        s = (home + i) % TABLE_SIZE;
        if (!share_used[s]) begin
          share_used[s]  = 1'b1;
          share_frame[s] = frame;
          share_count[s] = COUNT_ONE;
          r.ref_count    = REF_BITS'(1);
          hit            = s;
          break;
        end
        if (share_frame[s] == frame) begin
          if (share_count[s] != COUNT_MAX) share_count[s] += 1'b1;
          r.found     = 1'b1;
          r.ref_count = REF_BITS'(share_count[s]);
          hit         = s;
          break;
        end
      end
      if (hit < 0) r.dropped = 1'b1;
    end else begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        s = (home + i) % TABLE_SIZE;
        if (!share_used[s]) break;
        if (share_frame[s] == frame) begin
          hit = s;
          break;
        end
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        if (mode == MODE_DROP) begin
          if (share_count[hit] > COUNT_ONE) begin
            share_count[hit] -= 1'b1;
            r.ref_count = REF_BITS'(share_count[hit]);
          end else begin
            share_used[hit]  = 1'b0;
            share_count[hit] = '0;
            r.release_frame  = 1'b1;
          end
        end else begin
          r.ref_count = REF_BITS'(share_count[hit]);
        end
      end
    end
    return r;
  endfunction

  task automatic issue_request(input logic [MODE_BITS-1:0]  mode,
                               input logic [FRAME_BITS-1:0] frame,
                               input bit                    typed,
                               input res_t                  want);
    res_t predicted;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= frame;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    predicted = refcount_update(mode, frame);
    refcount_replies.push_back(typed ? want : predicted);
  endtask

  // sink side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    res_t got;
    res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = res_t'({out_tuser, out_tdata});
        if (refcount_replies.size() == 0) begin
          $error("unexpected reply: ref_count %0d found %0b release_frame %0b dropped %0b",
                 got.ref_count, got.found, got.release_frame, got.dropped);
          bad_fields++;
        end else begin
          want = refcount_replies.pop_front();
          if (got.ref_count !== want.ref_count) begin
            $error("ref_count: expected %0d, got %0d", want.ref_count, got.ref_count);
            bad_fields++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            bad_fields++;
          end
          if (got.release_frame !== want.release_frame) begin
            $error("release_frame: expected %0b, got %0b", want.release_frame,
                   got.release_frame);
            bad_fields++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
            bad_fields++;
          end
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[frame_share_count_table] ERROR");
    $finish;
  end

  initial begin
    logic [MODE_BITS-1:0]  mode;
    logic [FRAME_BITS-1:0] frame;
    logic [FRAME_BITS-1:0] pool [POOL_N];
    int                    pick;
    int                    pool_base;
    bad_fields = 0;
    idle_en    = 1'b1;
    long_hold  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    foreach (share_used[i]) begin
      share_used[i]  = 1'b0;
      share_frame[i] = '0;
      share_count[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      issue_request(dir_rows[i].mode, dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        pool_base = ($urandom_range(0, 3) == 0) ? TABLE_SIZE - 3
                                                : $urandom_range(0, TABLE_SIZE - 1);
        foreach (pool[k])
          pool[k] = {(FRAME_BITS-SLOT_BITS)'({$urandom(), $urandom()}),
                     SLOT_BITS'(pool_base + $urandom_range(0, 5))};
      end
      if (n == 500) long_hold = 1'b1;
      if (n == N_RANDOM - N_QUIET) idle_en = 1'b0;
      pick = $urandom_range(0, 99);
      mode = (pick < 45) ? MODE_ADD :
             (pick < 80) ? MODE_DROP :
             (pick < 95) ? MODE_QUERY : MODE_QUERY_ALT;
      frame = ($urandom_range(0, 6) == 0) ? FRAME_BITS'({$urandom(), $urandom()})
                                          : pool[$urandom_range(0, POOL_N - 1)];
      issue_request(mode, frame, 1'b0, RES_ABSENT);
    end
    in_tvalid <= 1'b0;

    while (refcount_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("[frame_share_count_table] OK");
    end else begin
      $display("[frame_share_count_table] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/fsct_pkg.sv
sv/fsct_ram.sv
sv/frame_share_count_table.sv
dv/tb_frame_share_count_table.sv
